[hw/rtl/cfnl_pkg.sv]
// Shared types, codes and the query fold for the case-folded name table.
// No dependencies; imported by the top level.
package cfnl_pkg;

    localparam int NAME_W = 64;
    localparam int FILE_NUM_W = 4;
    localparam int POS_W = 31;
    localparam int SIZE_W = 31;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FOUND     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [NAME_W-1:0]     entry_name;
        logic [FILE_NUM_W-1:0] file_number;
        logic [POS_W-1:0]      byte_position;
        logic [SIZE_W-1:0]     byte_size;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FILE_NUM_W-1:0] found_file;
        logic [POS_W-1:0]      found_position;
        logic [SIZE_W-1:0]     found_size;
    } rsp_word_t;

    // Fold a-z to upper case byte by byte; every other byte passes unchanged.
    function automatic logic [NAME_W-1:0] fold_upper(input logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] res;
        logic [7:0]        c;
        res = '0;
        for (int k = 0; k < 8; k++) begin
            c = name[8*k +: 8];
            if (c >= 8'h61 && c <= 8'h7A) begin
                c = c - 8'h20;
            end
            res[8*k +: 8] = c;
        end
        return res;
    endfunction

endpackage

[hw/rtl/case_folded_name_table_lookup.sv]
// Top level of the case-folded name table: command decode, table scan, result register.
// Depends on cfnl_pkg and cfnl_ram.
//
// A directory of up to ENTRIES named entries kept in one synchronous RAM.
// Each command word clears the table, appends one entry, or looks up a name
// (the spare opcode changes nothing); every command yields exactly one response
// word. A clear or a load goes through the hold state to the response
// register. A lookup folds a-z in the query to upper case, then reads the
// table through the single RAM read port one entry per cycle in load order,
// stopping at the first exact match; a miss ends at the last loaded entry.
// One command is in work at a time; the next is accepted once the response
// has moved into the output register, even while that register still waits
// on rsp_stall. A load into a full table stores nothing and reports table
// full. Stored file numbers are reduced modulo FILES. The table has no
// clearing pass: only entries below the fill count are ever read.
module case_folded_name_table_lookup #(
    parameter int ENTRIES = 4096,
    parameter int FILES   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  cfnl_pkg::cmd_word_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cfnl_pkg::rsp_word_t rsp
);

    import cfnl_pkg::*;

    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int FILE_W  = (FILES >= 16) ? FILE_NUM_W : ((FILES > 1) ? $clog2(FILES) : 1);
    localparam int ENTRY_W = NAME_W + FILE_W + POS_W + SIZE_W;

    // Field offsets inside one stored entry
    localparam int SIZE_LSB = 0;
    localparam int POS_LSB  = SIZE_LSB + SIZE_W;
    localparam int FILE_LSB = POS_LSB + POS_W;
    localparam int NAME_LSB = FILE_LSB + FILE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              issue_reg, issue_next;   // a read is being issued this cycle
    logic              dv_reg, dv_next;         // read data valid this cycle
    logic              dlast_reg, dlast_next;   // read data is the last loaded entry
    logic [NAME_W-1:0] query_reg, query_next;
    rsp_word_t         res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_reg;
    logic              rsp_load;

    logic               cmd_accept;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;
    logic               issue_last;

    // File number reduction table, one entry per possible file_number code
    logic [FILE_W-1:0] file_fold [2**FILE_NUM_W];

    for (genvar k = 0; k < 2**FILE_NUM_W; k++)
    begin : g_file_fold
        assign file_fold[k] = FILE_W'(k % FILES);
    end

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign wr_data = {cmd.entry_name, file_fold[cmd.file_number],
                      cmd.byte_position, cmd.byte_size};

    assign rd_en      = (state_reg == ST_SCAN) && issue_reg;
    assign issue_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    cfnl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        issue_next = issue_reg;
        dv_next    = dv_reg;
        dlast_next = dlast_reg;
        query_next = query_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        rsp_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_next   = '0;
                    state_next = ST_HOLD;
                    case (cmd.opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            res_next.status = STAT_DONE;
                        end
                        OP_LOAD:
                        begin
                            if (count_reg == CNT_W'(ENTRIES))
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else
                            begin
                                // Append at the fill count; a later scan reads it
                                // no earlier than the cycle after this write.
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                res_next.status = STAT_DONE;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                query_next = fold_upper(cmd.entry_name);
                                idx_next   = '0;
                                issue_next = 1'b1;
                                dv_next    = 1'b0;
                                dlast_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.status = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue side: advance the read address until the last entry.
                if (issue_reg)
                begin
                    dv_next    = 1'b1;
                    dlast_next = issue_last;
                    if (issue_last)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    dv_next = 1'b0;
                end
                // Compare side: check the entry read last cycle.
                if (dv_reg)
                begin
                    if (rd_data[NAME_LSB +: NAME_W] == query_reg)
                    begin
                        res_next.status         = STAT_FOUND;
                        res_next.found_file     = FILE_NUM_W'(rd_data[FILE_LSB +: FILE_W]);
                        res_next.found_position = rd_data[POS_LSB +: POS_W];
                        res_next.found_size     = rd_data[SIZE_LSB +: SIZE_W];
                        issue_next = 1'b0;
                        dv_next    = 1'b0;
                        state_next = ST_HOLD;
                    end
                    else if (dlast_reg)
                    begin
                        res_next   = '0;
                        res_next.status = STAT_NOT_FOUND;
                        dv_next    = 1'b0;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                // Hand the result over once the output register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            dlast_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            issue_reg     <= issue_next;
            dv_reg        <= dv_next;
            dlast_reg     <= dlast_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        res_reg   <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Table writes happen only on an accepted command.
    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> cmd_accept && (cmd.opcode == OP_LOAD))
        else $error("table write without an accepted load");

    // Fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond table depth");

    // Scan addresses stay below the fill count.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan address beyond loaded entries");

    // A load into a non-full table grows the count by one.
    a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd.opcode == OP_LOAD) && (count_reg != CNT_W'(ENTRIES)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("load did not advance the fill count");

    // A held result reaches the output register once it is free.
    a_hold_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HOLD) && (!rsp_valid_reg || !rsp_stall))
        |=> (rsp_valid_reg && (state_reg == ST_IDLE)))
        else $error("held result not delivered");

endmodule

[hw/rtl/cfnl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cfnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
